[hdl/kss_pkg.sv]
package kss_pkg;

  // Capacity of the sorting chain: one cell per stored sample.
  localparam int MAX_SAMPLES = 1024;

  localparam int VAL_W  = 32;
  localparam int RANK_W = 10;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  typedef struct packed {
    logic signed [VAL_W-1:0]  sample;
    logic                     last_sample;
    logic        [RANK_W-1:0] rank;
  } kss_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] selected_value;
    logic                    rank_error;
    logic                    overflow;
  } kss_out_t;

  // One slot of the chain: a value and whether it holds a sample.
  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
  } kss_slot_t;

  // Chain-wide commands issued by the controller.
  typedef struct packed {
    logic flush;
    logic shift;
  } kss_ctl_t;

endpackage

[hdl/kth_smallest_select_core.sv]
// Rank selector. A set of signed 32-bit samples is loaded one request per
// cycle into a chain of sorting cells; the request marked last_sample also
// carries the zero-based rank. After the last request the block waits,
// counting down from the number of stored samples, until every sample has
// come to rest in the ascending chain, then shifts the chain toward its
// head rank times and presents the head cell as selected_value. The chain
// moves data one cell per cycle. A rank at or beyond the count skips the
// wait and shift and answers with rank_error set and value 0. Samples
// beyond the capacity of MAX_SAMPLES cells are dropped and reported
// through overflow on that set's result. New requests are taken only while
// the block is loading; a finished result waits in the output register and
// the next set may load meanwhile.
module kth_smallest_select_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kss_pkg::kss_in_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output kss_pkg::kss_out_t out_req
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [kss_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [kss_pkg::CNT_W-1:0]  wait_r, wait_nxt;
  logic [kss_pkg::RANK_W-1:0] rank_r, rank_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       bad_r, bad_nxt;
  kss_pkg::kss_slot_t         feed_r, feed_nxt;
  kss_pkg::kss_out_t          out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;

  kss_pkg::kss_ctl_t          ctl;
  kss_pkg::kss_slot_t         ins_w  [kss_pkg::MAX_SAMPLES+1];
  kss_pkg::kss_slot_t         held_w [kss_pkg::MAX_SAMPLES];

  logic                       accept;
  logic                       full;
  logic                       out_free;
  logic [kss_pkg::CNT_W-1:0]  count_after;

  // The controller only takes requests while loading a set.
  assign in_stall = (state_r != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == kss_pkg::CNT_W'(kss_pkg::MAX_SAMPLES));
  assign out_free = !out_valid_r || !out_stall;

  // Stored count once the current request has been taken into account.
  assign count_after = full ? count_r : count_r + kss_pkg::CNT_W'(1);

  // The chain is cleared in the same cycle the result is written out, and
  // it shifts one place toward the head per remaining rank step.
  assign ctl = '{flush: (state_r == ST_DONE) && out_free,
                 shift: (state_r == ST_SHIFT) && (rank_r != '0)};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wait_nxt      = wait_r;
    rank_nxt      = rank_r;
    ovf_nxt       = ovf_r;
    bad_nxt       = bad_r;
    feed_nxt      = feed_r;
    feed_nxt.vld  = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            feed_nxt.vld = 1'b1;
            feed_nxt.val = in_req.sample;
            count_nxt    = count_after;
          end
          if (in_req.last_sample) begin
            rank_nxt = in_req.rank;
            wait_nxt = count_after;
            bad_nxt  = (kss_pkg::CMP_W'(in_req.rank) >= kss_pkg::CMP_W'(count_after));
            if (kss_pkg::CMP_W'(in_req.rank) >= kss_pkg::CMP_W'(count_after)) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SETTLE;
            end
          end
        end
      end
      ST_SETTLE: begin
        // The last sample needs at most count cells of travel to come to rest.
        if (wait_r == '0) begin
          state_nxt = ST_SHIFT;
        end else begin
          wait_nxt = wait_r - kss_pkg::CNT_W'(1);
        end
      end
      ST_SHIFT: begin
        if (rank_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          rank_nxt = rank_r - kss_pkg::RANK_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_nxt.selected_value = bad_r ? '0 : held_w[0].val;
          out_nxt.rank_error     = bad_r;
          out_nxt.overflow       = ovf_r;
          out_valid_nxt          = 1'b1;
          count_nxt              = '0;
          ovf_nxt                = 1'b0;
          state_nxt              = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      wait_r      <= '0;
      rank_r      <= '0;
      ovf_r       <= 1'b0;
      bad_r       <= 1'b0;
      feed_r.vld  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wait_r      <= wait_nxt;
      rank_r      <= rank_nxt;
      ovf_r       <= ovf_nxt;
      bad_r       <= bad_nxt;
      feed_r      <= feed_nxt;
      out_r       <= out_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The sorting chain. Each cell takes new samples from its left neighbor
  // and, while shifting, its right neighbor's stored value. The pass output
  // of the final cell never carries a sample, since the count is capped.
  assign ins_w[0] = feed_r;

  for (genvar i = 0; i < kss_pkg::MAX_SAMPLES; i++) begin : g_chain
    kss_pkg::kss_slot_t nbr_w;
    if (i == kss_pkg::MAX_SAMPLES - 1) begin : g_tail
      assign nbr_w = '0;
    end else begin : g_body
      assign nbr_w = held_w[i+1];
    end
    kss_cell u_slot (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .ins  (ins_w[i]),
      .nbr  (nbr_w),
      .held (held_w[i]),
      .pass (ins_w[i+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

endmodule

[hdl/kss_cell.sv]
module kss_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  kss_pkg::kss_ctl_t ctl,
  input  kss_pkg::kss_slot_t ins,
  input  kss_pkg::kss_slot_t nbr,
  output kss_pkg::kss_slot_t held,
  output kss_pkg::kss_slot_t pass
);

  kss_pkg::kss_slot_t held_r, held_nxt;
  kss_pkg::kss_slot_t pass_r, pass_nxt;

  // A cell keeps the smaller of its own value and the arriving one and
  // hands the larger to the right, so the chain stays sorted ascending.
  always_comb begin
    held_nxt     = held_r;
    pass_nxt     = pass_r;
    pass_nxt.vld = 1'b0;
    if (ctl.flush) begin
      held_nxt.vld = 1'b0;
    end else if (ctl.shift) begin
      held_nxt = nbr;
    end else if (ins.vld) begin
      if (!held_r.vld) begin
        held_nxt = ins;
      end else if (ins.val < held_r.val) begin
        held_nxt = ins;
        pass_nxt = held_r;
      end else begin
        pass_nxt = ins;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.vld <= 1'b0;
      pass_r.vld <= 1'b0;
    end else begin
      held_r <= held_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign held = held_r;
  assign pass = pass_r;

endmodule

[hdl/kss_checker.sv]
module kss_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input kss_pkg::kss_in_t  in_req,
  input logic              out_valid,
  input logic              out_stall,
  input kss_pkg::kss_out_t out_req
);

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A waiting result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_req))
    else $error("result changed while stalled");

  // A rejected rank always reports a zero value.
  a_bad_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.rank_error |-> out_req.selected_value == '0)
    else $error("rank error with nonzero value");

  // A result never appears in the cycle right after a request was taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared during loading");

endmodule

bind kth_smallest_select_core kss_checker u_kss_checker (.*);
